### rtl/core/dai_pkg.sv
// shared types and constants for the decimal ascii to integer parser
package dai_pkg;

    // config port layout and register indexes
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE   = 8'd1;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_MINUS = 8'd45;

    // range limits
    localparam logic [63:0] LIM32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] NEG32 = 64'h0000_0000_8000_0000;
    localparam logic [63:0] POS32 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LIM64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS64 = 64'h7FFF_FFFF_FFFF_FFFF;

    // character classes
    typedef enum logic [1:0] {
        CLS_WS,
        CLS_DIGIT,
        CLS_MINUS,
        CLS_OTHER
    } t_cls;

    // parse phase
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_NUM,
        PH_DONE
    } t_phase;

    // one classified character in the queue
    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
        logic       last;
    } t_item;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // mode registers
    typedef struct packed {
        logic signed_mode;
        logic wide_mode;
    } t_cfg;

endpackage

### rtl/core/dai_front.sv
// front end: accepts characters and classifies them for the queue
module dai_front (
    input  logic             i_in_valid,
    input  logic [7:0]       i_char_code,
    input  logic             i_last_char,
    input  dai_pkg::t_q_stat i_q_stat,
    output logic             o_in_stall,
    output logic             o_push,
    output dai_pkg::t_item   o_item
);
    import dai_pkg::*;

    logic w_ws;
    logic w_dig;
    logic [7:0] w_off;

    // character class decode
    always_comb begin
        w_ws  = (i_char_code == CH_SPACE) ||
                (i_char_code >= CH_TAB && i_char_code <= CH_CR);
        w_dig = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        w_off = i_char_code - CH_ZERO;
        o_item.digit = w_off[3:0];
        o_item.last  = i_last_char;
        if (w_ws) begin
            o_item.cls = CLS_WS;
        end else if (w_dig) begin
            o_item.cls = CLS_DIGIT;
        end else if (i_char_code == CH_MINUS) begin
            o_item.cls = CLS_MINUS;
        end else begin
            o_item.cls = CLS_OTHER;
        end
    end

    // stall while the queue is full
    assign o_in_stall = i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

endmodule

### rtl/core/dai_fifo.sv
// short queue of classified characters between front and back
module dai_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dai_pkg::t_item   i_item,
    input  logic             i_pop,
    output dai_pkg::t_item   o_head,
    output dai_pkg::t_q_stat o_stat
);
    import dai_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));

endmodule

### rtl/core/dai_back.sv
// back end: digit accumulation, range check and result register
module dai_back #(
    parameter int unsigned MAX_CHARS = 255
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dai_pkg::t_cfg    i_cfg,
    input  dai_pkg::t_item   i_head,
    input  dai_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [63:0]      o_parsed_value,
    output logic             o_parse_ok,
    output logic [7:0]       o_chars_used
);
    import dai_pkg::*;

    localparam logic [7:0] CAP = 8'((MAX_CHARS < 255) ? MAX_CHARS : 255);

    // parse state
    t_phase      r_phase,  n_phase;
    logic [63:0] r_acc,    n_acc;
    logic        r_neg,    n_neg;
    logic        r_failed, n_failed;
    logic [7:0]  r_used,   n_used;

    // pending result stage
    logic        r_p_valid;
    logic [63:0] r_p_acc;
    logic        r_p_neg;
    logic        r_p_good;
    logic [7:0]  r_p_used;
    logic        r_p_signed;
    logic        r_p_wide;

    // output stage
    logic        r_o_valid;
    logic [63:0] r_o_value;
    logic        r_o_ok;
    logic [7:0]  r_o_used;

    logic        w_p_move;
    logic        w_p_free;
    logic        w_fire;
    logic [65:0] w_sum;
    logic        w_digit_bad;
    logic [7:0]  w_used_inc;
    logic [63:0] w_lim;
    logic        w_ok;
    logic [63:0] w_value;

    // handshake between the stages
    assign w_p_move = r_p_valid && (!r_o_valid || !i_out_stall);
    assign w_p_free = !r_p_valid || w_p_move;
    assign w_fire   = !i_q_stat.empty && (!i_head.last || w_p_free);
    assign o_pop    = w_fire;

    // times ten plus digit, with overflow at the selected width
    always_comb begin
        w_sum = 66'({r_acc, 3'b000}) + 66'({r_acc, 1'b0}) + 66'(i_head.digit);
        if (i_cfg.wide_mode) begin
            w_digit_bad = (r_acc[63:61] != '0) || (w_sum[65:64] != '0);
        end else begin
            w_digit_bad = (r_acc[63:29] != '0) || (w_sum[65:32] != '0);
        end
        w_used_inc = (r_used < CAP) ? r_used + 8'd1 : r_used;
    end

    // next parse state for the head character
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_failed = r_failed;
        n_used   = r_used;
        if (!r_failed) begin
            case (r_phase)
                PH_SKIP: begin
                    if (i_head.cls == CLS_WS) begin
                        n_used = w_used_inc;
                    end else if (i_head.cls == CLS_DIGIT) begin
                        n_phase = PH_NUM;
                        if (w_digit_bad) begin
                            n_failed = 1'b1;
                        end else begin
                            n_acc  = w_sum[63:0];
                            n_used = w_used_inc;
                        end
                    end else if (i_head.cls == CLS_MINUS && i_cfg.signed_mode) begin
                        n_neg   = 1'b1;
                        n_used  = w_used_inc;
                        n_phase = PH_NUM;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_NUM: begin
                    if (i_head.cls == CLS_DIGIT) begin
                        if (w_digit_bad) begin
                            n_failed = 1'b1;
                        end else begin
                            n_acc  = w_sum[63:0];
                            n_used = w_used_inc;
                        end
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SKIP;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_failed <= 1'b0;
            r_used   <= '0;
        end else if (w_fire) begin
            if (i_head.last) begin
                r_phase  <= PH_SKIP;
                r_acc    <= '0;
                r_neg    <= 1'b0;
                r_failed <= 1'b0;
                r_used   <= '0;
            end else begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_neg    <= n_neg;
                r_failed <= n_failed;
                r_used   <= n_used;
            end
        end
    end

    // capture the closed string for the range check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_fire && i_head.last) begin
            r_p_valid <= 1'b1;
        end else if (w_p_move) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && i_head.last) begin
            r_p_acc    <= n_acc;
            r_p_neg    <= n_neg;
            r_p_good   <= !n_failed && (n_phase != PH_SKIP);
            r_p_used   <= n_used;
            r_p_signed <= i_cfg.signed_mode;
            r_p_wide   <= i_cfg.wide_mode;
        end
    end

    // final range check and sign
    always_comb begin
        if (r_p_neg) begin
            w_lim = r_p_wide ? NEG64 : NEG32;
        end else if (r_p_signed) begin
            w_lim = r_p_wide ? POS64 : POS32;
        end else begin
            w_lim = r_p_wide ? LIM64 : LIM32;
        end
        w_ok = r_p_good && (r_p_acc <= w_lim);
        if (!w_ok) begin
            w_value = '0;
        end else if (r_p_neg) begin
            w_value = 64'd0 - r_p_acc;
        end else begin
            w_value = r_p_acc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_p_move) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_move) begin
            r_o_value <= w_value;
            r_o_ok    <= w_ok;
            r_o_used  <= w_ok ? r_p_used : 8'd0;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_parsed_value = r_o_value;
    assign o_parse_ok     = r_o_ok;
    assign o_chars_used   = r_o_used;

endmodule

### rtl/core/decimal_ascii_to_integer_top.sv
// top level of the decimal ascii to integer parser
// throughput: one character per cycle, set by the accumulate loop in the back end
// unless output stall holds back a closing character; results pass the queue,
// the range-check stage and the output register, and output stall can delay them
// reset: synchronous active low; clears parse state, queue and output valid,
// signed_mode returns to 1 and wide_mode to 0; no clearing pass
module decimal_ascii_to_integer_top #(
    parameter int unsigned MAX_CHARS = 255,
    parameter int unsigned Q_DEPTH   = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_char_code,
    input  logic                            i_last_char,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [63:0]                     o_parsed_value,
    output logic                            o_parse_ok,
    output logic [7:0]                      o_chars_used,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dai_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dai_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dai_pkg::*;

    t_cfg    r_cfg;
    t_item   w_push_item;
    t_item   w_head;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;

    // mode registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.signed_mode <= 1'b1;
            r_cfg.wide_mode   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_SIGNED_MODE) begin
                r_cfg.signed_mode <= i_cfg_data[0];
            end else if (i_cfg_index == REG_WIDE_MODE) begin
                r_cfg.wide_mode <= i_cfg_data[0];
            end
        end
    end

    dai_front u_front (
        .i_in_valid  (i_in_valid),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_q_stat    (w_q_stat),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    dai_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    dai_back #(
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (w_head),
        .i_q_stat       (w_q_stat),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_parsed_value (o_parsed_value),
        .o_parse_ok     (o_parse_ok),
        .o_chars_used   (o_chars_used)
    );

    // a failed parse reports zero value and zero count
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_parse_ok |-> o_parsed_value == 64'd0 && o_chars_used == 8'd0)
        else $error("failed result carries nonzero value or count");

    // a good parse has consumed at least one character
    a_ok_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_parse_ok |-> o_chars_used != 8'd0)
        else $error("good result with zero characters used");

    // the back end never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("queue popped while empty");

    // input stall only when the queue holds items
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> !w_q_stat.empty)
        else $error("input stalled with empty queue");

endmodule

### tb/decimal_ascii_to_integer_top_tb.sv
// self-checking testbench for the decimal ascii to integer parser
module decimal_ascii_to_integer_top_tb;
    import dai_pkg::*;

    localparam int unsigned CHAR_LIMIT  = 255;
    localparam int unsigned COUNT_CAP   = (CHAR_LIMIT < 255) ? CHAR_LIMIT : 255;
    localparam int unsigned CHAR_GOAL   = 1100;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [63:0] TOP32 = 64'h0000_0000_E000_0000;
    localparam logic [63:0] TOP64 = 64'hE000_0000_0000_0000;
    localparam logic [63:0] RANGE_POINTS [7] =
        '{64'd0, LIM32, NEG32, POS32, LIM64, NEG64, POS64};

    // one parsed number as the block reports it
    typedef struct {
        logic [63:0] value;
        logic        ok;
        logic [7:0]  used;
    } t_number;

    // running parse of the character stream and the numbers still owed
    class number_board;
        logic        sign_en;
        logic        wide_en;
        t_phase      phase;
        logic [63:0] acc;
        logic        neg;
        logic        failed;
        logic [7:0]  used;
        t_number     pending_numbers[$];
        int unsigned errors;

        function new();
            sign_en = 1'b1;
            wide_en = 1'b0;
            errors  = 0;
            clear();
        endfunction

        function void clear();
            phase  = PH_SKIP;
            acc    = 64'd0;
            neg    = 1'b0;
            failed = 1'b0;
            used   = 8'd0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SIGNED_MODE) begin
                sign_en = data[0];
            end else if (idx == REG_WIDE_MODE) begin
                wide_en = data[0];
            end
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void bump_count();
            if (used < COUNT_CAP) used++;
        endfunction

        // multiply by ten and add, failing on any carry past the selected width
        function void add_digit(logic [7:0] c);
            logic [63:0] lim, top, d, r8, r2;
            lim = wide_en ? LIM64 : LIM32;
            top = wide_en ? TOP64 : TOP32;
            d   = c - CH_ZERO;
            if (acc > lim || (acc & top) != 64'd0) begin
                failed = 1'b1;
                return;
            end
            r8 = (acc << 3) & lim;
            r2 = (acc << 1) & lim;
            if (r2 > lim - r8) begin
                failed = 1'b1;
                return;
            end
            acc = r8 + r2;
            if (d > lim - acc) begin
                failed = 1'b1;
                return;
            end
            acc = acc + d;
            bump_count();
        endfunction

        // advance the parse by one accepted character
        function void take_char(logic [7:0] c, logic last);
            t_number num;
            logic [63:0] value;
            logic ok;
            if (!failed) begin
                case (phase)
                    PH_SKIP: begin
                        if (c != 8'd0 && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                            bump_count();
                        end else if (is_digit(c)) begin
                            phase = PH_NUM;
                            add_digit(c);
                        end else if (c == CH_MINUS && sign_en) begin
                            neg = 1'b1;
                            bump_count();
                            phase = PH_NUM;
                        end else begin
                            failed = 1'b1;
                        end
                    end
                    PH_NUM: begin
                        if (is_digit(c)) add_digit(c);
                        else phase = PH_DONE;
                    end
                    default: ;
                endcase
            end
            if (!last) return;

            // final range check at the end of the string
            value = 64'd0;
            ok = !failed && phase != PH_SKIP;
            if (ok) begin
                if (neg) begin
                    if (acc > (wide_en ? NEG64 : NEG32)) ok = 1'b0;
                    else value = 64'd0 - acc;
                end else if (sign_en) begin
                    if (acc > (wide_en ? POS64 : POS32)) ok = 1'b0;
                    else value = acc;
                end else begin
                    if (acc > (wide_en ? LIM64 : LIM32)) ok = 1'b0;
                    else value = acc;
                end
            end
            num.value = ok ? value : 64'd0;
            num.ok    = ok;
            num.used  = ok ? used : 8'd0;
            pending_numbers.insert(pending_numbers.size(), num);
            clear();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_number(logic [63:0] value, logic ok, logic [7:0] used_in);
            t_number want;
            if (pending_numbers.size() == 0) begin
                note_error($sformatf("unexpected result: value %h ok %0b used %0d",
                                     value, ok, used_in));
                return;
            end
            want = pending_numbers.pop_front();
            if (value !== want.value || ok !== want.ok || used_in !== want.used) begin
                note_error($sformatf({"mismatch: expected value %h ok %0b used %0d, ",
                                      "got value %h ok %0b used %0d"},
                                     want.value, want.ok, want.used, value, ok, used_in));
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_char_code;
    logic                  i_last_char;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [63:0]           o_parsed_value;
    logic                  o_parse_ok;
    logic [7:0]            o_chars_used;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    number_board board = new();
    logic [7:0]  line_buf[$];
    int unsigned chars_sent = 0;
    int unsigned cycles = 0;

    decimal_ascii_to_integer_top #(
        .MAX_CHARS(CHAR_LIMIT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_code   (i_char_code),
        .i_last_char   (i_last_char),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_parsed_value(o_parsed_value),
        .o_parse_ok    (o_parse_ok),
        .o_chars_used  (o_chars_used),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            board.check_number(o_parsed_value, o_parse_ok, o_chars_used);
        end
    end

    // output stall: free stretches, short bursts and a few long holds
    initial begin
        int r;
        i_out_stall <= 1'b0;
        repeat (4) @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(5, 40)) @(posedge i_clk);
            end else if (r < 85) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [7:0] pick_ws();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
    endfunction

    // append one character to the string being built
    task automatic add_char(logic [7:0] c);
        line_buf = {line_buf, c};
    endtask

    task automatic push_text(string s);
        for (int k = 0; k < s.len(); k++) add_char(s[k]);
    endtask

    task automatic push_ws(int n);
        repeat (n) add_char(pick_ws());
    endtask

    // one character beat, held until accepted
    task automatic send_beat(logic [7:0] c, logic last);
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.take_char(c, last);
        chars_sent++;
    endtask

    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = (r < 55) ? 0 : (r < 85) ? $urandom_range(1, 3) :
            (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // send the buffered string, last flag on its final character
    task automatic send_line();
        bit calm;
        calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < line_buf.size(); k++) begin
            send_beat(line_buf[k], k == line_buf.size() - 1);
            if (!calm) idle_gap();
        end
        line_buf.delete();
    endtask

    // hold off input until every owed number has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending_numbers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // config beat; the caller lowers valid after its last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        board.set_reg(idx, data);
    endtask

    // random string: mostly well formed numbers, some broken ones, some noise
    task automatic build_random_line();
        int r, kind, n;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            push_ws(($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 8));
            if ($urandom_range(0, 99) < 35) add_char(CH_MINUS);
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                // near a range limit of either width
                v = RANGE_POINTS[$urandom_range(0, 6)] + 64'($urandom_range(0, 4)) - 64'd2;
                push_text($sformatf("%0d", v));
            end else if (kind < 9) begin
                n = (kind < 8) ? $urandom_range(1, 21) : $urandom_range(1, 3);
                repeat (n) add_char(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(0, 255)));
            end
        end else if (r < 85) begin
            repeat ($urandom_range(1, 5)) begin
                n = $urandom_range(0, 2);
                add_char((n == 0) ? pick_ws() :
                         (n == 1) ? CH_MINUS : 8'($urandom_range(0, 255)));
            end
        end else begin
            repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
        end
    endtask

    // stimulus
    initial begin
        int unsigned goal;
        int n, k;
        logic sign_sel, wide_sel;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_char_code <= 8'd0;
        i_last_char <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_SIGNED_MODE;
        i_cfg_data  <= 8'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed strings under reset modes (signed, 32 bit)
        add_char(CH_MINUS);
        send_line();
        push_text(" 7x");
        send_line();
        add_char(8'h00);
        send_line();
        push_ws(2);
        send_line();
        add_char(8'hFF);
        push_text("5");
        send_line();
        push_text("+1");
        send_line();
        push_text("-9");
        add_char(8'h00);
        send_line();
        push_text("0");
        send_line();
        push_text("2147483648");
        send_line();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // new mode setting once the block is idle
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: begin sign_sel = 1'b0; wide_sel = 1'b0; end
                    2: begin sign_sel = 1'b1; wide_sel = 1'b1; end
                    3: begin sign_sel = 1'b0; wide_sel = 1'b1; end
                    4: begin sign_sel = 1'b1; wide_sel = 1'b0; end
                    default: begin
                        sign_sel = 1'($urandom_range(0, 1));
                        wide_sel = 1'($urandom_range(0, 1));
                    end
                endcase
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(REG_SIGNED_MODE, {7'd0, sign_sel});
                    write_reg(REG_WIDE_MODE, {7'd0, wide_sel});
                end else begin
                    write_reg(REG_WIDE_MODE, {7'd0, wide_sel});
                    write_reg(REG_SIGNED_MODE, {7'd0, sign_sel});
                end
                i_cfg_valid <= 1'b0;
            end

            goal = chars_sent + CHAR_GOAL / NUM_PHASES;
            while (chars_sent < goal) begin
                if ((p == 2 && chars_sent + CHAR_GOAL / NUM_PHASES == goal)
                        || $urandom_range(0, 199) == 0) begin
                    // long string so the consumed count nears or reaches its saturation cap
                    n = $urandom_range(250, 300);
                    k = $urandom_range(0, n);
                    push_ws(k);
                    repeat (n - k) add_char(CH_ZERO);
                    push_text("5");
                end else begin
                    build_random_line();
                end
                send_line();
                if ($urandom_range(0, 19) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (board.errors == 0 && board.pending_numbers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
